// ===== hdl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

	// Decoder phases of the front end
	typedef enum logic [2:0] {
		PH_NORMAL,
		PH_ESCAPE,
		PH_HEX1,
		PH_WAIT_BS,
		PH_WAIT_U,
		PH_HEX2
	} phase_t;

	// Result kinds
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_QUOTE = 2'd1;
	localparam logic [1:0] KIND_NUL   = 2'd2;
	localparam logic [1:0] KIND_ERROR = 2'd3;

	// Error codes
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_HEX  = 2'd1;
	localparam logic [1:0] ERR_CODE = 2'd2;
	localparam logic [1:0] ERR_SURR = 2'd3;

	// Characters with a special meaning
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LC_B   = 8'h62;
	localparam logic [7:0] CH_LC_F   = 8'h66;
	localparam logic [7:0] CH_LC_N   = 8'h6E;
	localparam logic [7:0] CH_LC_R   = 8'h72;
	localparam logic [7:0] CH_LC_T   = 8'h74;
	localparam logic [7:0] CH_LC_U   = 8'h75;

	// Control codes the short escapes map to
	localparam logic [7:0] CTL_BS = 8'h08;
	localparam logic [7:0] CTL_FF = 8'h0C;
	localparam logic [7:0] CTL_LF = 8'h0A;
	localparam logic [7:0] CTL_CR = 8'h0D;
	localparam logic [7:0] CTL_HT = 8'h09;

	// Code point bounds
	localparam int unsigned CpWidth = 21;
	localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
	localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
	localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
	localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
	localparam logic [CpWidth-1:0] SUPP_BASE = 21'h10000;

	// Command queue geometry
	localparam int unsigned FifoDepth = 4;
	localparam int unsigned FifoAw    = $clog2(FifoDepth);

	// One command from front to back: a single result, or a code point to encode
	typedef struct packed {
		logic               is_cp;
		logic [1:0]         kind;
		logic [7:0]         data;
		logic [1:0]         err;
		logic [CpWidth-1:0] cp;
	} cmd_t;

endpackage

// ===== hdl/json_string_unescape_utf8_core.sv =====
// Top level of the JSON string unescaper with UTF-8 output.
//
// Input channel: one byte of a JSON string body per beat (char_in), starting
// after the opening quote, with in_valid/in_ready. Output channel: result
// beats (kind, out_byte, error_code, last) with out_valid/out_ready; last
// marks the final beat caused by one input byte. A byte may cause no beat
// (backslash, partial hex escape, completed high surrogate), one beat, or up
// to four UTF-8 bytes for a completed code point.
// A decoder front takes one byte every cycle while the queue has room and
// writes a command into a four-entry queue; an encoder back drains the queue
// at one beat per cycle while beats are taken. With the queue empty, a
// byte's command enters the queue as the byte is accepted, and its first
// beat is then registered. in_ready falls only when the queue is full.
// When the receiver stalls, the output beat holds and the queue fills; the
// front keeps taking bytes until the queue has no room.
// Reset clears the decoder to normal text and empties the queue and output.
module json_string_unescape_utf8_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic [1:0] error_code,
	output logic       last
);
	import jsu_pkg::*;

	cmd_t wr_cmd;
	cmd_t head;
	logic push;
	logic pop;
	logic full;
	logic empty;

	// Decoder front
	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.char_in  (char_in),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.full     (full),
		.push     (push),
		.cmd      (wr_cmd)
	);

	// Command queue
	jsu_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	// Encoder back
	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.out_byte   (out_byte),
		.error_code (error_code),
		.last       (last)
	);

endmodule

// ===== hdl/jsu_front.sv =====
// Front end: accepts string bytes, runs the escape decoder, issues commands.
module jsu_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    char_in,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          full,
	output logic          push,
	output jsu_pkg::cmd_t cmd
);
	import jsu_pkg::*;

	phase_t      phase_q, phase_d;
	logic [1:0]  hex_cnt_q, hex_cnt_d;
	logic [15:0] first_q, first_d;
	logic [15:0] second_q, second_d;
	logic        accept;
	logic        emit;
	logic        hex_ok;
	logic [3:0]  hex_val;
	logic [15:0] unit_new;

	assign in_ready = !full;
	assign accept   = in_valid && !full;
	assign push     = accept && emit;

	// Decode one hex digit
	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (char_in inside {[8'h30:8'h39]}) begin
			hex_val = 4'(char_in - 8'h30);
		end else if (char_in inside {[8'h61:8'h66]}) begin
			hex_val = 4'(char_in - 8'h61 + 8'd10);
		end else if (char_in inside {[8'h41:8'h46]}) begin
			hex_val = 4'(char_in - 8'h41 + 8'd10);
		end else begin
			hex_ok = 1'b0;
		end
	end

	// Shift the digit into the unit being built
	always_comb begin
		if (phase_q == PH_HEX2) begin
			unit_new = {second_q[11:0], hex_val};
		end else begin
			unit_new = {first_q[11:0], hex_val};
		end
	end

	// Hold decoder state until an input byte is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_NORMAL;
			hex_cnt_q <= 2'd0;
			first_q   <= 16'd0;
			second_q  <= 16'd0;
		end else if (accept) begin
			phase_q   <= phase_d;
			hex_cnt_q <= hex_cnt_d;
			first_q   <= first_d;
			second_q  <= second_d;
		end
	end

	// Next phase and command for the current byte
	always_comb begin
		phase_d   = phase_q;
		hex_cnt_d = hex_cnt_q;
		first_d   = first_q;
		second_d  = second_q;
		emit      = 1'b0;
		cmd       = '0;
		case (phase_q)
			PH_ESCAPE: begin
				phase_d  = PH_NORMAL;
				emit     = 1'b1;
				cmd.kind = KIND_DATA;
				case (char_in)
					CH_NUL:  cmd.kind = KIND_NUL;
					CH_LC_B: cmd.data = CTL_BS;
					CH_LC_F: cmd.data = CTL_FF;
					CH_LC_N: cmd.data = CTL_LF;
					CH_LC_R: cmd.data = CTL_CR;
					CH_LC_T: cmd.data = CTL_HT;
					CH_LC_U: begin
						emit      = 1'b0;
						phase_d   = PH_HEX1;
						hex_cnt_d = 2'd0;
						first_d   = 16'd0;
					end
					default: cmd.data = char_in;
				endcase
			end
			PH_HEX1, PH_HEX2: begin
				if (!hex_ok) begin
					emit      = 1'b1;
					cmd.kind  = KIND_ERROR;
					cmd.err   = ERR_HEX;
					phase_d   = PH_NORMAL;
					hex_cnt_d = 2'd0;
				end else begin
					if (phase_q == PH_HEX2) begin
						second_d = unit_new;
					end else begin
						first_d = unit_new;
					end
					if (hex_cnt_q != 2'd3) begin
						hex_cnt_d = hex_cnt_q + 2'd1;
					end else begin
						hex_cnt_d = 2'd0;
						if (phase_q == PH_HEX2) begin
							emit      = 1'b1;
							cmd.is_cp = 1'b1;
							cmd.cp    = SUPP_BASE + {1'b0, first_q[9:0], unit_new[9:0]};
							phase_d   = PH_NORMAL;
						end else if (unit_new inside {[LOW_SURR_MIN:LOW_SURR_MAX]}
								|| unit_new == 16'd0) begin
							emit     = 1'b1;
							cmd.kind = KIND_ERROR;
							cmd.err  = ERR_CODE;
							phase_d  = PH_NORMAL;
						end else if (unit_new inside {[HIGH_SURR_MIN:HIGH_SURR_MAX]}) begin
							phase_d = PH_WAIT_BS;
						end else begin
							emit      = 1'b1;
							cmd.is_cp = 1'b1;
							cmd.cp    = {5'd0, unit_new};
							phase_d   = PH_NORMAL;
						end
					end
				end
			end
			PH_WAIT_BS: begin
				if (char_in != CH_BSLASH) begin
					emit      = 1'b1;
					cmd.kind  = KIND_ERROR;
					cmd.err   = ERR_SURR;
					phase_d   = PH_NORMAL;
					hex_cnt_d = 2'd0;
				end else begin
					phase_d = PH_WAIT_U;
				end
			end
			PH_WAIT_U: begin
				if (char_in != CH_LC_U) begin
					emit      = 1'b1;
					cmd.kind  = KIND_ERROR;
					cmd.err   = ERR_SURR;
					phase_d   = PH_NORMAL;
					hex_cnt_d = 2'd0;
				end else begin
					phase_d   = PH_HEX2;
					hex_cnt_d = 2'd0;
					second_d  = 16'd0;
				end
			end
			default: begin
				phase_d = PH_NORMAL;
				emit    = 1'b1;
				case (char_in)
					CH_QUOTE:  cmd.kind = KIND_QUOTE;
					CH_NUL:    cmd.kind = KIND_NUL;
					CH_BSLASH: begin
						emit    = 1'b0;
						phase_d = PH_ESCAPE;
					end
					default: begin
						cmd.kind = KIND_DATA;
						cmd.data = char_in;
					end
				endcase
			end
		endcase
	end

endmodule

// ===== hdl/jsu_fifo.sv =====
// Short command queue between the decoder front and the encoder back.
module jsu_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jsu_pkg::cmd_t wr_cmd,
	input  logic          pop,
	output jsu_pkg::cmd_t head,
	output logic          full,
	output logic          empty
);
	import jsu_pkg::*;

	cmd_t              mem_q [FifoDepth];
	logic [FifoAw-1:0] wr_ptr_q;
	logic [FifoAw-1:0] rd_ptr_q;
	logic [FifoAw:0]   count_q;

	assign full  = (count_q == (FifoAw+1)'(FifoDepth));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Write the entry at the tail
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/jsu_back.sv =====
// Back end: turns queued commands into result beats, UTF-8 one byte a beat.
module jsu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  jsu_pkg::cmd_t head,
	input  logic          empty,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    kind,
	output logic [7:0]    out_byte,
	output logic [1:0]    error_code,
	output logic          last
);
	import jsu_pkg::*;

	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] byte_q;
	logic [1:0] err_q;
	logic       last_q;
	logic [1:0] idx_q;
	logic       load;
	logic       take;
	logic [1:0] len_m1;
	logic [1:0] shift_sel;
	logic [7:0] lead_byte;
	logic [7:0] cont_byte;
	logic [7:0] beat_byte;
	logic       beat_last;

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign out_byte   = byte_q;
	assign error_code = err_q;
	assign last       = last_q;

	assign load = !out_valid_q || out_ready;
	assign take = load && !empty;
	assign pop  = take && beat_last;

	// Size the UTF-8 sequence
	always_comb begin
		if (head.cp < 21'h80) begin
			len_m1    = 2'd0;
			lead_byte = head.cp[7:0];
		end else if (head.cp < 21'h800) begin
			len_m1    = 2'd1;
			lead_byte = 8'hC0 | {3'd0, head.cp[10:6]};
		end else if (head.cp < 21'h10000) begin
			len_m1    = 2'd2;
			lead_byte = 8'hE0 | {4'd0, head.cp[15:12]};
		end else begin
			len_m1    = 2'd3;
			lead_byte = 8'hF0 | {5'd0, head.cp[20:18]};
		end
	end

	// Pick the continuation byte for the current position
	always_comb begin
		shift_sel = len_m1 - idx_q;
		case (shift_sel)
			2'd0:    cont_byte = 8'h80 | {2'd0, head.cp[5:0]};
			2'd1:    cont_byte = 8'h80 | {2'd0, head.cp[11:6]};
			2'd2:    cont_byte = 8'h80 | {2'd0, head.cp[17:12]};
			default: cont_byte = 8'h80;
		endcase
	end

	// Form the beat
	always_comb begin
		if (head.is_cp) begin
			beat_byte = (idx_q == 2'd0) ? lead_byte : cont_byte;
			beat_last = (idx_q == len_m1);
		end else begin
			beat_byte = head.data;
			beat_last = 1'b1;
		end
	end

	// Hold the output beat until taken; advance position in the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= !empty;
			end
			if (take) begin
				idx_q <= beat_last ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	// Load beat payload
	always_ff @(posedge clk) begin
		if (take) begin
			kind_q <= head.is_cp ? KIND_DATA : head.kind;
			byte_q <= beat_byte;
			err_q  <= head.is_cp ? ERR_NONE : head.err;
			last_q <= beat_last;
		end
	end

endmodule
